// File: rtl/core/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg: shared constants and tables for the point-to-spherical converter
// Default widths, fixed datapath sizes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package sps_pkg;

  // Default configuration
  localparam int COORD_WIDTH_DEF   = 20;
  localparam int ANGLE_WIDTH_DEF   = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  // Fixed internal formats
  localparam int ATAN_ENTRIES = 24;   // table depth; extra stages are skipped
  localparam int FRAC_TOTAL   = 32;   // coordinates and angles are scaled to 32 bits
  localparam int ROOT_BITS    = 32;   // root bits produced by each square root
  localparam int RAD_WIDTH    = 64;   // radicand and remainder width
  localparam int DP_WIDTH     = 44;   // CORDIC x/y datapath width
  localparam int ACC_WIDTH    = 34;   // angle accumulator, units of pi/2^31
  localparam int MAG_WIDTH    = 40;   // normalized magnitude field
  localparam int NORM_MSB     = 39;   // target msb after normalization
  localparam int SHIFT_WIDTH  = 6;    // normalization shift count

  // atan(2^-i) in units of pi/2^31, rounded
  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/scan_point_to_spherical_top.sv
// Stages: 2 squaring stages, 32 root-digit stages, 1 rounding, 4 normalization
//   stages, one stage per CORDIC rotation, 1 output register.
// Throughput: one point per cycle; every stage holds on a stalled output.
// Reset: synchronous rst clears the stage valid bits and out_valid only.
// ----------------------------------------------------------------------------
// scan_point_to_spherical_top
// Converts a 3-D point to theta, phi and range with pipelined square roots
// and two lockstep vectoring CORDIC lanes.
// ----------------------------------------------------------------------------
module scan_point_to_spherical_top
  import sps_pkg::*;
#(
  parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] x_coord,
  input  logic signed [COORD_WIDTH-1:0] y_coord,
  input  logic signed [COORD_WIDTH-1:0] z_coord,
  input  logic                          point_valid,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [ANGLE_WIDTH-1:0] theta_angle,
  output logic signed [ANGLE_WIDTH-1:0] phi_angle,
  output logic        [COORD_WIDTH-1:0] depth_range,
  output logic                          theta_undefined,
  output logic                          phi_undefined
);

  localparam int CW   = COORD_WIDTH;
  localparam int FRAC = FRAC_TOTAL - COORD_WIDTH;
  localparam int NC   = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
  localparam int LAT  = 3 + ROOT_BITS + 1 + 4 + NC;
  localparam int RSH  = FRAC_TOTAL - ANGLE_WIDTH;

  localparam logic signed [ACC_WIDTH-1:0] QACC  = ACC_WIDTH'(1) <<< (ANGLE_WIDTH - 2);
  localparam logic signed [ACC_WIDTH-1:0] HALFR = ACC_WIDTH'(1) <<< (RSH - 1);
  localparam logic [ANGLE_WIDTH-1:0]      QANG  = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 2);

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 pv;
  } side_t;

  typedef struct packed {
    logic          t_spec;
    logic          t_zero;
    logic          t_neg;
    logic          p_spec;
    logic          p_zero;
    logic          p_neg;
    logic [CW-1:0] depth;
  } tail_t;

  // Global advance: every stage moves when the output register can take data
  logic           adv;
  logic [LAT-1:0] vp;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else if (adv) begin
      vp <= {vp[LAT-2:0], in_valid};
    end
  end

  // Stage 0: capture the point
  logic signed [CW-1:0] x0, y0, z0;
  logic                 pv0;

  always_ff @(posedge clk) begin
    if (adv) begin
      x0  <= x_coord;
      y0  <= y_coord;
      z0  <= z_coord;
      pv0 <= point_valid;
    end
  end

  // Stage 1: square the magnitudes
  logic [CW-1:0]   ax0, ay0, az0;
  logic [2*CW-1:0] xx1, yy1, zz1;
  side_t           sd1;

  assign ax0 = x0[CW-1] ? CW'(-x0) : CW'(x0);
  assign ay0 = y0[CW-1] ? CW'(-y0) : CW'(y0);
  assign az0 = z0[CW-1] ? CW'(-z0) : CW'(z0);

  always_ff @(posedge clk) begin
    if (adv) begin
      xx1 <= (2*CW)'(ax0) * (2*CW)'(ax0);
      yy1 <= (2*CW)'(ay0) * (2*CW)'(ay0);
      zz1 <= (2*CW)'(az0) * (2*CW)'(az0);
      sd1 <= {x0, y0, z0, pv0};
    end
  end

  // Stage 2 and root-digit stages: one root bit per stage for both roots
  logic [RAD_WIDTH-1:0] hrem  [0:ROOT_BITS];
  logic [ROOT_BITS-1:0] hroot [0:ROOT_BITS];
  logic [RAD_WIDTH-1:0] drem  [0:ROOT_BITS];
  logic [ROOT_BITS-1:0] droot [0:ROOT_BITS];
  side_t                sqs   [0:ROOT_BITS];

  always_ff @(posedge clk) begin
    if (adv) begin
      hrem[0]  <= (RAD_WIDTH'(xx1) + RAD_WIDTH'(yy1)) << (2 * FRAC);
      hroot[0] <= '0;
      drem[0]  <= RAD_WIDTH'(xx1) + RAD_WIDTH'(yy1) + RAD_WIDTH'(zz1);
      droot[0] <= '0;
      sqs[0]   <= sd1;
    end
  end

  for (genvar gj = 0; gj < ROOT_BITS; gj++) begin : g_root
    localparam int K = ROOT_BITS - 1 - gj;
    logic [RAD_WIDTH-1:0] htrial, dtrial;

    assign htrial = (RAD_WIDTH'(hroot[gj]) << (K + 1)) | (RAD_WIDTH'(1) << (2 * K));
    assign dtrial = (RAD_WIDTH'(droot[gj]) << (K + 1)) | (RAD_WIDTH'(1) << (2 * K));

    // Try this root bit; keep it when the remainder covers the trial value
    always_ff @(posedge clk) begin
      if (adv) begin
        if (hrem[gj] >= htrial) begin
          hrem[gj+1]  <= hrem[gj] - htrial;
          hroot[gj+1] <= hroot[gj] | (ROOT_BITS'(1) << K);
        end else begin
          hrem[gj+1]  <= hrem[gj];
          hroot[gj+1] <= hroot[gj];
        end
        if (drem[gj] >= dtrial) begin
          drem[gj+1]  <= drem[gj] - dtrial;
          droot[gj+1] <= droot[gj] | (ROOT_BITS'(1) << K);
        end else begin
          drem[gj+1]  <= drem[gj];
          droot[gj+1] <= droot[gj];
        end
        sqs[gj+1] <= sqs[gj];
      end
    end
  end

  // Round both roots to nearest
  logic [ROOT_BITS:0] hsum, dsum;
  logic [ROOT_BITS:0] rr;
  logic [CW-1:0]      depr;
  side_t              sdr;

  assign hsum = (ROOT_BITS+1)'(hroot[ROOT_BITS])
              + (ROOT_BITS+1)'(hrem[ROOT_BITS] > RAD_WIDTH'(hroot[ROOT_BITS]));
  assign dsum = (ROOT_BITS+1)'(droot[ROOT_BITS])
              + (ROOT_BITS+1)'(drem[ROOT_BITS] > RAD_WIDTH'(droot[ROOT_BITS]));

  always_ff @(posedge clk) begin
    if (adv) begin
      rr   <= hsum;
      depr <= sqs[ROOT_BITS].pv ? dsum[CW-1:0] : '0;
      sdr  <= sqs[ROOT_BITS];
    end
  end

  // Tail carry: flags and range ride along the angle stages
  tail_t tl [0:NC+3];

  always_ff @(posedge clk) begin
    if (adv) begin
      tl[0].t_spec <= (sdr.y == '0);
      tl[0].t_zero <= (sdr.x == '0);
      tl[0].t_neg  <= sdr.x[CW-1];
      tl[0].p_spec <= (sdr.x == '0) && (sdr.y == '0);
      tl[0].p_zero <= (sdr.z == '0);
      tl[0].p_neg  <= sdr.z[CW-1];
      tl[0].depth  <= depr;
    end
  end

  for (genvar gt = 1; gt <= NC + 3; gt++) begin : g_tail
    always_ff @(posedge clk) begin
      if (adv) begin
        tl[gt] <= tl[gt-1];
      end
    end
  end

  // P1: build the vector pairs, lane 0 for theta and lane 1 for phi
  logic signed [DP_WIDTH-1:0] a1 [0:1];
  logic signed [DP_WIDTH-1:0] b1 [0:1];
  logic signed [DP_WIDTH-1:0] yext, xext, zext;

  assign yext = DP_WIDTH'(sdr.y);
  assign xext = DP_WIDTH'(sdr.x);
  assign zext = DP_WIDTH'(sdr.z);

  always_ff @(posedge clk) begin
    if (adv) begin
      if (sdr.y > 0) begin
        a1[0] <= yext;
        b1[0] <= xext;
      end else begin
        a1[0] <= -yext;
        b1[0] <= -xext;
      end
      a1[1] <= signed'(DP_WIDTH'(rr));
      b1[1] <= zext <<< FRAC;
    end
  end

  // P2: magnitude for normalization
  logic signed [DP_WIDTH-1:0] a2 [0:1];
  logic signed [DP_WIDTH-1:0] b2 [0:1];
  logic [MAG_WIDTH-1:0]       m2 [0:1];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        logic signed [DP_WIDTH-1:0] ab;
        ab    = b1[l][DP_WIDTH-1] ? -b1[l] : b1[l];
        m2[l] <= (a1[l] > ab) ? a1[l][MAG_WIDTH-1:0] : ab[MAG_WIDTH-1:0];
        a2[l] <= a1[l];
        b2[l] <= b1[l];
      end
    end
  end

  // P3: shift count that brings the msb to the target position
  function automatic logic [SHIFT_WIDTH-1:0] msb_pos(input logic [MAG_WIDTH-1:0] m);
    logic [SHIFT_WIDTH-1:0] p;
    p = '0;
    for (int i = 0; i < MAG_WIDTH; i++) begin
      if (m[i]) begin
        p = SHIFT_WIDTH'(i);
      end
    end
    return p;
  endfunction

  logic signed [DP_WIDTH-1:0] a3 [0:1];
  logic signed [DP_WIDTH-1:0] b3 [0:1];
  logic [SHIFT_WIDTH-1:0]     k3 [0:1];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        k3[l] <= SHIFT_WIDTH'(NORM_MSB) - msb_pos(m2[l]);
        a3[l] <= a2[l];
        b3[l] <= b2[l];
      end
    end
  end

  // P4 and CORDIC rotations
  logic signed [DP_WIDTH-1:0]  ca   [0:NC][0:1];
  logic signed [DP_WIDTH-1:0]  cb   [0:NC][0:1];
  logic signed [ACC_WIDTH-1:0] cacc [0:NC][0:1];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        ca[0][l]   <= a3[l] <<< k3[l];
        cb[0][l]   <= b3[l] <<< k3[l];
        cacc[0][l] <= '0;
      end
    end
  end

  for (genvar gi = 0; gi < NC; gi++) begin : g_cordic
    logic signed [ACC_WIDTH-1:0] ang;

    assign ang = signed'(ACC_WIDTH'(atan_entry(5'(gi))));

    // Rotate toward the x axis; the sign of b picks the direction
    always_ff @(posedge clk) begin
      if (adv) begin
        for (int l = 0; l < 2; l++) begin
          if (!cb[gi][l][DP_WIDTH-1]) begin
            ca[gi+1][l]   <= ca[gi][l] + (cb[gi][l] >>> gi);
            cb[gi+1][l]   <= cb[gi][l] - (ca[gi][l] >>> gi);
            cacc[gi+1][l] <= cacc[gi][l] + ang;
          end else begin
            ca[gi+1][l]   <= ca[gi][l] - (cb[gi][l] >>> gi);
            cb[gi+1][l]   <= cb[gi][l] + (ca[gi][l] >>> gi);
            cacc[gi+1][l] <= cacc[gi][l] - ang;
          end
        end
      end
    end
  end

  // Output: round, clamp, override the axis cases
  function automatic logic [ANGLE_WIDTH-1:0] to_angle(input logic signed [ACC_WIDTH-1:0] acc);
    logic signed [ACC_WIDTH-1:0] sum, shf;
    sum = acc + HALFR;
    shf = sum >>> RSH;
    if (shf > QACC) begin
      shf = QACC;
    end else if (shf < -QACC) begin
      shf = -QACC;
    end
    return shf[ANGLE_WIDTH-1:0];
  endfunction

  logic [ANGLE_WIDTH-1:0] theta_next, phi_next;
  tail_t                  tend;

  assign tend = tl[NC+3];

  always_comb begin
    if (tend.t_spec) begin
      theta_next = tend.t_zero ? '0 : (tend.t_neg ? ANGLE_WIDTH'(-QANG) : QANG);
    end else begin
      theta_next = to_angle(cacc[NC][0]);
    end
    if (tend.p_spec) begin
      phi_next = tend.p_zero ? '0 : (tend.p_neg ? ANGLE_WIDTH'(-QANG) : QANG);
    end else begin
      phi_next = to_angle(cacc[NC][1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vp[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      theta_angle     <= theta_next;
      phi_angle       <= phi_next;
      depth_range     <= tend.depth;
      theta_undefined <= tend.t_spec && tend.t_zero;
      phi_undefined   <= tend.p_spec && tend.p_zero;
    end
  end

  // Checks
  a_theta_undef_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && theta_undefined |-> theta_angle == '0)
    else $error("theta not zero while undefined");

  a_phi_implies_theta: assert property (@(posedge clk) disable iff (rst)
    out_valid && phi_undefined |-> theta_undefined && depth_range == '0)
    else $error("phi undefined without theta undefined or zero range");

  a_theta_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> theta_angle <= signed'(QANG) && theta_angle >= -signed'(QANG))
    else $error("theta out of range");

  a_phi_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> phi_angle <= signed'(QANG) && phi_angle >= -signed'(QANG))
    else $error("phi out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !in_ready |=> $stable(vp))
    else $error("pipeline moved during stall");

endmodule

// File: tb/sv/scan_point_to_spherical_top_test.sv
// ----------------------------------------------------------------------------
// scan_point_to_spherical_top_test
// Drives points through the converter with random gaps and stalls, predicts
// theta, phi, range and the two flags per point, and checks each transfer.
// ----------------------------------------------------------------------------
module scan_point_to_spherical_top_test;
  import sps_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int AW = ANGLE_WIDTH_DEF;
  localparam int NST = CORDIC_STAGES_DEF;
  localparam int PIPE_LAT = 40 + ((NST < ATAN_ENTRIES) ? NST : ATAN_ENTRIES);

  typedef struct packed {
    logic signed [AW-1:0] theta;
    logic signed [AW-1:0] phi;
    logic [CW-1:0]        depth;
    logic                 t_undef;
    logic                 p_undef;
  } sph_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CW-1:0] x_coord = '0;
  logic signed [CW-1:0] y_coord = '0;
  logic signed [CW-1:0] z_coord = '0;
  logic point_valid = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [AW-1:0] theta_angle;
  logic signed [AW-1:0] phi_angle;
  logic [CW-1:0] depth_range;
  logic theta_undefined;
  logic phi_undefined;

  sph_t expected_q[$];
  int mismatches = 0;
  bit hold_off = 1'b0;

  always #5 clk = ~clk;

  scan_point_to_spherical_top u_top (.*);

  // rounded integer square root
  function automatic longint unsigned root_round(input longint unsigned n);
    longint unsigned rem, res, b;
    rem = n; res = 0; b = 64'd1 << 62;
    while (b > rem) b >>= 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    if (rem > res) res++;
    return res;
  endfunction

  // vectoring CORDIC angle of (a, b), a > 0, in output units
  function automatic longint vector_angle(input longint a, input longint b);
    longint mag, acc, da, db, q;
    int k, sh;
    mag = (b < 0) ? -b : b;
    if (a > mag) mag = a;
    acc = 0; k = 0; sh = 32 - AW; q = 64'sd1 <<< (AW - 2);
    while (mag < (64'sd1 <<< 39) && k < 40) begin
      mag = mag <<< 1;
      k++;
    end
    a = a <<< k;
    b = b <<< k;
    for (int i = 0; i < NST && i < 24; i++) begin
      da = b >>> i;
      db = a >>> i;
      if (b >= 0) begin
        a += da; b -= db; acc += longint'(atan_entry(i[4:0]));
      end else begin
        a -= da; b += db; acc -= longint'(atan_entry(i[4:0]));
      end
    end
    acc = (acc + (64'sd1 <<< (sh - 1))) >>> sh;
    if (acc > q) acc = q;
    if (acc < -q) acc = -q;
    return acc;
  endfunction

  function automatic sph_t spherical_of(input logic signed [CW-1:0] xi,
      input logic signed [CW-1:0] yi, input logic signed [CW-1:0] zi,
      input logic pv);
    sph_t r;
    longint x, y, z, q, th, ph;
    longint unsigned hsq;
    int f;
    x = xi; y = yi; z = zi;
    q = 64'sd1 <<< (AW - 2);
    f = 32 - CW;
    r = '0;
    hsq = x * x + y * y;
    if (y == 0) begin
      if (x > 0) th = q;
      else if (x < 0) th = -q;
      else begin th = 0; r.t_undef = 1'b1; end
    end else if (y > 0) begin
      th = vector_angle(y, x);
    end else begin
      th = vector_angle(-y, -x);
    end
    if (hsq == 0) begin
      if (z > 0) ph = q;
      else if (z < 0) ph = -q;
      else begin ph = 0; r.p_undef = 1'b1; end
    end else begin
      ph = vector_angle(longint'(root_round(hsq << (2 * f))), z <<< f);
    end
    if (pv) r.depth = CW'(root_round(hsq + z * z));
    r.theta = th[AW-1:0];
    r.phi = ph[AW-1:0];
    return r;
  endfunction

  function automatic int short_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  // offer one point and hold it until the transfer
  task automatic send_point(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
      input logic signed [CW-1:0] z, input logic pv, input bit gaps);
    int g;
    g = gaps ? short_gap() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    x_coord <= x; y_coord <= y; z_coord <= z; point_valid <= pv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(spherical_of(x, y, z, pv));
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
  endtask

  // check each result transfer against the oldest prediction
  always @(posedge clk) begin
    sph_t got, exp_r;
    if (!rst && out_valid && out_ready) begin
      got = '{theta_angle, phi_angle, depth_range, theta_undefined, phi_undefined};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", exp_r, got);
        end
      end
    end
  end

  // randomize output readiness; hold off completely during a stall phase
  always @(posedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else if ($urandom_range(0, 19) == 0) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
  end

  task automatic test_corners();
    logic signed [CW-1:0] mx, mn;
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    send_point(0, 0, 0, 1, 0);
    send_point(0, 0, 5, 1, 0);
    send_point(0, 0, -5, 0, 0);
    send_point(7, 0, 3, 1, 0);
    send_point(-7, 0, 3, 1, 0);
    send_point(0, 9, 0, 1, 0);
    send_point(0, -9, 0, 1, 0);
    send_point(mx, mx, mx, 1, 0);
    send_point(mn, mn, mn, 1, 0);
    send_point(mn, mn, mn, 0, 0);
    send_point(mx, mn, mx, 1, 0);
    send_point(mn, 1, mx, 1, 0);
    send_point(1, mn, mn, 1, 0);
    send_point(-1, -1, -1, 1, 0);
    send_point(1, 1, 1, 1, 0);
    send_point(mx, 0, 0, 1, 0);
    send_point(0, mn, 0, 1, 0);
    send_point(123, -456, 789, 0, 0);
    release_input();
  endtask

  task automatic test_random(input int n);
    logic signed [CW-1:0] v[3];
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < 3; j++) begin
        case ($urandom_range(0, 5))
          0: v[j] = '0;
          1: v[j] = CW'($signed(CW'($urandom_range(0, 15))) - 8);
          default: v[j] = CW'($urandom);
        endcase
      end
      send_point(v[0], v[1], v[2], $urandom_range(0, 3) != 0, i % 200 >= 60);
    end
    release_input();
  endtask

  // stall the output long enough for the pipeline to fill while points keep coming
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (3 * PIPE_LAT) @(posedge clk);
        hold_off = 1'b0;
      end
      test_random(2 * PIPE_LAT);
    join
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corners();
    test_random(1200);
    test_backpressure();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("scan_point_to_spherical_top_test: clean");
    end else begin
      $display("scan_point_to_spherical_top_test: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("scan_point_to_spherical_top_test: errors");
    $finish;
  end

endmodule
